>>> sv/ect_pkg.sv
package ect_pkg;

	localparam int unsigned DIV_W = 32;
	localparam int unsigned CNT_W = $clog2(DIV_W);
	localparam int unsigned DSR_W = 6;
	localparam int unsigned DAYS_W = 16;

	localparam logic [DSR_W-1:0] SEC_PER_MIN = 6'd60;
	localparam logic [DSR_W-1:0] HR_PER_DAY = 6'd24;
	localparam logic [11:0] EPOCH_YEAR = 12'd1970;
	localparam logic [DAYS_W-1:0] QUAD_DAYS = 16'd1461;
	localparam logic [DAYS_W-1:0] LEAP_DAYS = 16'd366;
	localparam logic [DAYS_W-1:0] NORM_DAYS = 16'd365;
	localparam logic [3:0] LAST_MONTH = 4'd11;
	localparam logic [3:0] FEB = 4'd1;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0] month;
		logic [4:0] day;
	} walk_res_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd0: len = 5'd31;
			4'd1: len = leap ? 5'd29 : 5'd28;
			4'd2: len = 5'd31;
			4'd3: len = 5'd30;
			4'd4: len = 5'd31;
			4'd5: len = 5'd30;
			4'd6: len = 5'd31;
			4'd7: len = 5'd31;
			4'd8: len = 5'd30;
			4'd9: len = 5'd31;
			4'd10: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

>>> sv/ect_serdiv.sv
module ect_serdiv (
	input  logic clk,
	input  logic arst_n,
	input  ect_pkg::div_req_t req,
	output logic done,
	output logic [ect_pkg::DIV_W-1:0] quo,
	output logic [ect_pkg::DSR_W-1:0] rem
);
	import ect_pkg::*;

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] num_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W:0] trial;
	logic [DSR_W:0] diff;
	logic ge;

	// restoring division, one quotient bit per cycle shifted into the dividend
	assign trial = {rem_q, num_q[DIV_W-1]};
	assign ge = trial >= {1'b0, dsr_q};
	assign diff = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			dsr_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				num_q <= req.dividend;
				rem_q <= '0;
				dsr_q <= req.divisor;
			end else if (busy_q) begin
				num_q <= {num_q[DIV_W-2:0], ge};
				rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo = num_q;
	assign rem = rem_q;

	a_rem_below_dsr: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dsr_q)
		else $error("remainder not below divisor");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("divider did not start");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start && cnt_q == CNT_W'(DIV_W - 1) |=> done_q && !busy_q)
		else $error("divider did not finish after last bit");
endmodule

>>> sv/ect_calwalk.sv
module ect_calwalk (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ect_pkg::DAYS_W-1:0] days,
	output logic done,
	output ect_pkg::walk_res_t res
);
	import ect_pkg::*;

	typedef enum logic [1:0] {W_IDLE, W_QUAD, W_YEAR, W_MONTH} walk_state_t;

	walk_state_t state_q;
	logic [DAYS_W-1:0] days_q;
	logic [11:0] year_q;
	logic [3:0] m_q;
	logic done_q;
	walk_res_t res_q;
	logic leap;
	logic [DAYS_W-1:0] ylen;
	logic [DAYS_W-1:0] mlen;

	assign leap = year_q[1:0] == 2'd0;
	assign ylen = leap ? LEAP_DAYS : NORM_DAYS;
	assign mlen = {{(DAYS_W-5){1'b0}}, month_len(m_q, leap)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			days_q <= '0;
			year_q <= '0;
			m_q <= '0;
			done_q <= 1'b0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				W_IDLE: begin
					if (start) begin
						days_q <= days;
						year_q <= EPOCH_YEAR;
						state_q <= W_QUAD;
					end
				end
				// four years from 1970 always span one leap year
				W_QUAD: begin
					if (days_q >= QUAD_DAYS) begin
						days_q <= days_q - QUAD_DAYS;
						year_q <= year_q + 12'd4;
					end else begin
						state_q <= W_YEAR;
					end
				end
				W_YEAR: begin
					if (days_q < ylen) begin
						m_q <= '0;
						state_q <= W_MONTH;
					end else begin
						days_q <= days_q - ylen;
						year_q <= year_q + 12'd1;
					end
				end
				W_MONTH: begin
					if (days_q < mlen || m_q == LAST_MONTH) begin
						res_q.year <= year_q;
						res_q.month <= m_q + 4'd1;
						res_q.day <= days_q[4:0] + 5'd1;
						done_q <= 1'b1;
						state_q <= W_IDLE;
					end else begin
						days_q <= days_q - mlen;
						m_q <= m_q + 4'd1;
					end
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == W_IDLE)
		else $error("walk started while busy");
	a_month_days: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == W_MONTH |-> days_q < LEAP_DAYS)
		else $error("day count too large for month walk");
	a_done_day: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> res_q.day != 5'd0 && res_q.month != 4'd0)
		else $error("walk produced empty day or month");
endmodule

>>> sv/epoch_to_calendar_fields.sv
// flow: an accepted item passes through three bit-serial divisions (by 60, 60 and 24),
// then the calendar walk (four-year blocks, single years, months), and then reaches the
// output register
// one item at a time: the next item is taken the cycle after the result moves to the
// output register, which waits while date_stall holds the previous result
// reset: arst_n clears the sequencer, divider, walker and output valid asynchronously
module epoch_to_calendar_fields (
	input  logic clk,
	input  logic arst_n,
	input  logic epoch_valid,
	output logic epoch_stall,
	input  logic [31:0] epoch_seconds,
	output logic date_valid,
	input  logic date_stall,
	output logic [11:0] year,
	output logic [3:0] month,
	output logic [4:0] day_of_month,
	output logic [4:0] hour,
	output logic [5:0] minute,
	output logic [5:0] second
);
	import ect_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_SEC, S_MIN, S_HR, S_WALK, S_DONE} seq_state_t;

	seq_state_t state_q;
	logic in_acc;
	div_req_t div_req;
	logic div_done;
	logic [DIV_W-1:0] div_quo;
	logic [DSR_W-1:0] div_rem;
	logic walk_start;
	logic walk_done;
	walk_res_t walk_res;
	logic [5:0] sec_q;
	logic [5:0] min_q;
	logic [4:0] hr_q;
	logic out_valid_q;
	logic [11:0] year_q;
	logic [3:0] month_q;
	logic [4:0] day_q;
	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [5:0] second_q;

	assign epoch_stall = state_q != S_IDLE;
	assign in_acc = epoch_valid && !epoch_stall;

	always_comb begin
		div_req.start = in_acc || (div_done && (state_q == S_SEC || state_q == S_MIN));
		div_req.dividend = in_acc ? epoch_seconds : div_quo;
		div_req.divisor = (in_acc || state_q == S_SEC) ? SEC_PER_MIN : HR_PER_DAY;
	end

	assign walk_start = div_done && state_q == S_HR;

	ect_serdiv u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.done(div_done),
		.quo(div_quo),
		.rem(div_rem)
	);

	ect_calwalk u_walk (
		.clk(clk),
		.arst_n(arst_n),
		.start(walk_start),
		.days(div_quo[DAYS_W-1:0]),
		.done(walk_done),
		.res(walk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			sec_q <= '0;
			min_q <= '0;
			hr_q <= '0;
			year_q <= '0;
			month_q <= '0;
			day_q <= '0;
			hour_q <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else begin
			if (out_valid_q && !date_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc)
						state_q <= S_SEC;
				end
				S_SEC: begin
					if (div_done) begin
						sec_q <= div_rem;
						state_q <= S_MIN;
					end
				end
				S_MIN: begin
					if (div_done) begin
						min_q <= div_rem;
						state_q <= S_HR;
					end
				end
				S_HR: begin
					if (div_done) begin
						hr_q <= div_rem[4:0];
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_done)
						state_q <= S_DONE;
				end
				// hold the finished item until the output register is free
				S_DONE: begin
					if (!out_valid_q || !date_stall) begin
						out_valid_q <= 1'b1;
						year_q <= walk_res.year;
						month_q <= walk_res.month;
						day_q <= walk_res.day;
						hour_q <= hr_q;
						minute_q <= min_q;
						second_q <= sec_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign date_valid = out_valid_q;
	assign year = year_q;
	assign month = month_q;
	assign day_of_month = day_q;
	assign hour = hour_q;
	assign minute = minute_q;
	assign second = second_q;

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> month_q >= 4'd1 && month_q <= 4'd12)
		else $error("month out of range");
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> hour_q < 5'd24 && minute_q < 6'd60 && second_q < 6'd60)
		else $error("time of day out of range");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> epoch_stall)
		else $error("sequencer did not start on accepted item");
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |-> state_q == S_WALK)
		else $error("walk finished outside walk state");
endmodule

>>> verif/tb_epoch_to_calendar_fields.sv
`timescale 1ns / 100ps

module tb_epoch_to_calendar_fields;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0] month;
		logic [4:0] day_of_month;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} calendar_date_t;

	localparam int unsigned FIRST_YEAR = 1970;
	localparam int unsigned SECS_PER_DAY = 86400;
	localparam int unsigned LAST_FULL_DAY = 49709;
	localparam int unsigned LAST_START_YEAR = 2105;
	localparam int unsigned DRAIN_CYCLES = 400;
	// month lengths, january in the low slot
	localparam logic [11:0][4:0] MONTH_DAYS = {
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
		5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic epoch_valid = 1'b0;
	logic epoch_stall;
	logic [31:0] epoch_seconds = '0;
	logic date_valid;
	logic date_stall = 1'b0;
	logic [11:0] year;
	logic [3:0] month;
	logic [4:0] day_of_month;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [5:0] second;

	calendar_date_t expected_dates[$];
	calendar_date_t next_date;
	int unsigned error_count = 0;
	bit gaps_enable = 1'b0;
	bit stall_enable = 1'b0;

	epoch_to_calendar_fields dut (
		.clk(clk),
		.arst_n(arst_n),
		.epoch_valid(epoch_valid),
		.epoch_stall(epoch_stall),
		.epoch_seconds(epoch_seconds),
		.date_valid(date_valid),
		.date_stall(date_stall),
		.year(year),
		.month(month),
		.day_of_month(day_of_month),
		.hour(hour),
		.minute(minute),
		.second(second)
	);

	always #5 clk = ~clk;

	function automatic calendar_date_t calendar_from_epoch(input logic [31:0] secs);
		int unsigned t;
		int unsigned days;
		int unsigned yr;
		int unsigned ylen;
		int unsigned mlen;
		int unsigned m;
		bit leap;
		bit found;
		calendar_date_t d;
		t = secs;
		d.second = 6'(t % 60);
		t = t / 60;
		d.minute = 6'(t % 60);
		t = t / 60;
		d.hour = 5'(t % 24);
		days = t / 24;
		yr = FIRST_YEAR;
		ylen = 365;
		if (yr % 4 == 0) begin
			ylen = 366;
		end
		while (days >= ylen) begin
			days = days - ylen;
			yr = yr + 1;
			ylen = (yr % 4 == 0) ? 366 : 365;
		end
		// every year divisible by four is leap, 2100 included
		leap = (yr % 4 == 0);
		d.month = 4'd1;
		found = 1'b0;
		for (m = 0; m < 12; m++) begin
			if (!found) begin
				mlen = 32'(MONTH_DAYS[4'(m)]);
				if (m == 1 && leap) begin
					mlen = 29;
				end
				if (days < mlen) begin
					d.month = 4'(m + 1);
					found = 1'b1;
				end else begin
					days = days - mlen;
				end
			end
		end
		d.year = 12'(yr);
		d.day_of_month = 5'(days + 1);
		return d;
	endfunction

	// valid stays high into the next item unless a gap is drawn
	task automatic send_epoch(input logic [31:0] secs);
		if (gaps_enable && $urandom_range(0, 99) < 7) begin
			epoch_valid <= 1'b0;
			repeat ($urandom_range(1, 170)) @(posedge clk);
		end
		epoch_valid <= 1'b1;
		epoch_seconds <= secs;
		do @(posedge clk); while (epoch_stall);
		expected_dates.push_back(calendar_from_epoch(secs));
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		date_stall <= stall_enable && ($urandom_range(0, 99) < 7);
	end

	always @(posedge clk) begin
		if (arst_n && date_valid && !date_stall) begin
			if (expected_dates.size() == 0) begin
				$error("date item with none expected: %0d-%0d-%0d", year, month, day_of_month);
				error_count++;
			end else begin
				next_date = expected_dates.pop_front();
				check_field("year", 32'(next_date.year), 32'(year));
				check_field("month", 32'(next_date.month), 32'(month));
				check_field("day_of_month", 32'(next_date.day_of_month),
					32'(day_of_month));
				check_field("hour", 32'(next_date.hour), 32'(hour));
				check_field("minute", 32'(next_date.minute), 32'(minute));
				check_field("second", 32'(next_date.second), 32'(second));
			end
		end
	end

	task automatic test_directed();
		logic [31:0] corners[$];
		corners = '{
			32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
			32'd31535999, 32'd31536000,
			// feb 29 and mar 1 of 1972
			32'd68169600, 32'd68255999, 32'd68256000,
			32'd94694399, 32'd951782400,
			32'h7FFFFFFF, 32'h80000000,
			// 2100 treated as a leap year
			32'd4102444799, 32'd4102444800, 32'd4107542400, 32'd4107628800,
			32'd4291833599, 32'd4291833600,
			32'hAAAAAAAA, 32'h55555555,
			32'hFFFFFFFE, 32'hFFFFFFFF
		};
		foreach (corners[i]) begin
			send_epoch(corners[i]);
		end
	endtask

	task automatic test_random(input int unsigned count);
		logic [31:0] secs;
		int unsigned yr;
		int unsigned start_day;
		int unsigned offset;
		int unsigned target;
		for (int unsigned n = 0; n < count; n++) begin
			case ($urandom_range(0, 3))
				0: secs = $urandom();
				1: begin
					secs = $urandom_range(0, LAST_FULL_DAY) * SECS_PER_DAY;
					secs = secs + ($urandom_range(0, 1) ? 0 : SECS_PER_DAY - 1);
				end
				2: begin
					// land on year ends and around the end of february
					target = $urandom_range(FIRST_YEAR, LAST_START_YEAR);
					start_day = 0;
					for (yr = FIRST_YEAR; yr < target; yr++) begin
						start_day = start_day + ((yr % 4 == 0) ? 366 : 365);
					end
					case ($urandom_range(0, 5))
						0: offset = 0;
						1: offset = 58;
						2: offset = 59;
						3: offset = 60;
						4: offset = 364;
						default: offset = (target % 4 == 0) ? 365 : 0;
					endcase
					secs = (start_day + offset) * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
				end
				default: secs = $urandom() >> $urandom_range(0, 31);
			endcase
			send_epoch(secs);
		end
	endtask

	task automatic test_steady_stream();
		gaps_enable = 1'b0;
		stall_enable = 1'b0;
		test_random(150);
	endtask

	task automatic test_idling_stream();
		gaps_enable = 1'b1;
		stall_enable = 1'b1;
		test_random(380);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_steady_stream();
		test_idling_stream();
		epoch_valid <= 1'b0;
		wait (expected_dates.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
